### rtl/dmph_pkg.sv
// ----------------------------------------------------------------------------
// dmph_pkg
// Shared types and constants for the dual modular polynomial hash check.
// ----------------------------------------------------------------------------
package dmph_pkg;

    localparam int HASH_W = 30;
    localparam int TERM_W = 9;
    localparam int PROD_W = HASH_W + TERM_W;
    localparam int QUOT_W = 9;

    localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_A   = 30'd29;
    localparam logic [HASH_W-1:0] BASE_B   = 30'd31;

    // floor(2^40 / HASH_MOD); quotient estimate undershoots by at most one
    localparam logic [10:0] BARRETT_C = 11'd1099;

    localparam logic REG_REF_A = 1'b0;
    localparam logic REG_REF_B = 1'b1;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
        logic              match;
    } result_item_t;

    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
        logic acc;
        logic flush;
    } lane_ctrl_t;

    // Quotient estimate for x < 32 * HASH_MOD, indexed by x[34:27]
    typedef logic [5:0] quot_tbl_t [256];

    function automatic quot_tbl_t build_quot_tbl();
        quot_tbl_t  t;
        longint     x;
        logic [5:0] q;
        for (int i = 0; i < 256; i++)
        begin
            x = longint'(i) <<< 27;
            q = '0;
            while (x >= longint'(HASH_MOD))
            begin
                x = x - longint'(HASH_MOD);
                q = q + 6'd1;
            end
            t[i] = q;
        end
        return t;
    endfunction

    localparam quot_tbl_t QUOT_TBL = build_quot_tbl();

endpackage

### rtl/dmph_stream_if.sv
// ----------------------------------------------------------------------------
// dmph_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dmph_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dmph_power.sv
// ----------------------------------------------------------------------------
// dmph_power
// Powers of both bases: stepped per accepted byte, reset to base on last.
// ----------------------------------------------------------------------------
module dmph_power (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      last,
    output logic [dmph_pkg::HASH_W-1:0] pow_a,
    output logic [dmph_pkg::HASH_W-1:0] pow_b
);
    import dmph_pkg::*;

    localparam int X_W = HASH_W + 5;

    function automatic logic [HASH_W-1:0] pow_step(
        input logic [HASH_W-1:0] p,
        input logic [HASH_W-1:0] base
    );
        logic [X_W-1:0] x;
        logic [5:0]     q;
        logic [X_W-1:0] r;
        x = X_W'(p) * X_W'(base);
        q = QUOT_TBL[x[X_W-1:X_W-8]];
        r = x - X_W'(q) * X_W'(HASH_MOD);
        if (r >= X_W'(HASH_MOD))
        begin
            r = r - X_W'(HASH_MOD);
        end
        return r[HASH_W-1:0];
    endfunction

    logic [HASH_W-1:0] pow_a_reg, pow_a_next;
    logic [HASH_W-1:0] pow_b_reg, pow_b_next;

    always_comb
    begin
        pow_a_next = pow_a_reg;
        pow_b_next = pow_b_reg;
        if (accept)
        begin
            pow_a_next = last ? BASE_A : pow_step(pow_a_reg, BASE_A);
            pow_b_next = last ? BASE_B : pow_step(pow_b_reg, BASE_B);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pow_a_reg <= BASE_A;
            pow_b_reg <= BASE_B;
        end
        else
        begin
            pow_a_reg <= pow_a_next;
            pow_b_reg <= pow_b_next;
        end
    end

    assign pow_a = pow_a_reg;
    assign pow_b = pow_b_reg;

endmodule

### rtl/dmph_lane.sv
// ----------------------------------------------------------------------------
// dmph_lane
// One hash lane: term times power, Barrett reduction, modular accumulate.
// ----------------------------------------------------------------------------
module dmph_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmph_pkg::lane_ctrl_t        ctrl,
    input  logic [dmph_pkg::TERM_W-1:0] term,
    input  logic [dmph_pkg::HASH_W-1:0] power,
    output logic [dmph_pkg::HASH_W-1:0] sum_next
);
    import dmph_pkg::*;

    logic [HASH_W-1:0] pow0_reg;
    logic [PROD_W-1:0] prod1_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [QUOT_W-1:0] quot2_reg;
    logic [HASH_W-1:0] rem3_reg;
    logic [HASH_W-1:0] sum_reg;

    logic [29:0]       est;
    logic [PROD_W-1:0] diff;
    logic [HASH_W:0]   diff_lo;
    logic [HASH_W:0]   rem;
    logic [HASH_W:0]   total;

    always_comb
    begin
        est     = 30'(prod1_reg[PROD_W-1:20]) * 30'(BARRETT_C);
        diff    = prod2_reg - PROD_W'(quot2_reg) * PROD_W'(HASH_MOD);
        diff_lo = diff[HASH_W:0];
        rem     = (diff_lo >= (HASH_W+1)'(HASH_MOD)) ? diff_lo - (HASH_W+1)'(HASH_MOD)
                                                     : diff_lo;
        total   = {1'b0, sum_reg} + {1'b0, rem3_reg};
        if (total >= (HASH_W+1)'(HASH_MOD))
        begin
            total = total - (HASH_W+1)'(HASH_MOD);
        end
        sum_next = total[HASH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld0)
        begin
            pow0_reg <= power;
        end
        if (ctrl.ld1)
        begin
            prod1_reg <= PROD_W'(term) * PROD_W'(pow0_reg);
        end
        if (ctrl.ld2)
        begin
            prod2_reg <= prod1_reg;
            quot2_reg <= est[20 +: QUOT_W];
        end
        if (ctrl.ld3)
        begin
            rem3_reg <= rem[HASH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            sum_reg <= ctrl.flush ? '0 : sum_next;
        end
    end

endmodule

### rtl/dual_modular_polynomial_hash_check.sv
// Result path: power, product, quotient and remainder registers, then accumulator.
// Throughput: one byte per cycle unless output stalls; power step is unpipelined.
// Reset: hashes restart, powers return to the bases, both references read 1.
// A stalled result holds only the final stage; bytes keep flowing until it fills.
// ----------------------------------------------------------------------------
// dual_modular_polynomial_hash_check
// Two polynomial hashes modulo 1000000007 (bases 29 and 31) over a byte
// stream, compared against programmable reference values at each last byte.
// ----------------------------------------------------------------------------
module dual_modular_polynomial_hash_check (
    input  logic                        clk,
    input  logic                        rst_n,
    dmph_stream_if.sink                 chars,
    dmph_stream_if.source               results,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [dmph_pkg::HASH_W-1:0] cfg_data
);
    import dmph_pkg::*;

    logic [HASH_W-1:0] ref_a_reg, ref_b_reg;
    logic [TERM_W-1:0] term_reg;
    logic [3:0]        vld_reg, vld_next;
    logic [3:0]        lst_reg;
    logic              out_valid_reg;
    result_item_t      out_data_reg;

    logic              accept, out_free, acc_take;
    logic [3:0]        en;
    logic [HASH_W-1:0] pow_a, pow_b;
    logic [HASH_W-1:0] sum_a_next, sum_b_next;
    lane_ctrl_t        ctrl;
    char_item_t        in_item;

    assign in_item  = chars.data;
    assign out_free = !out_valid_reg || results.ready;
    assign acc_take = vld_reg[3] && (!lst_reg[3] || out_free);
    assign en[3]    = !vld_reg[3] || acc_take;
    assign en[2]    = !vld_reg[2] || en[3];
    assign en[1]    = !vld_reg[1] || en[2];
    assign en[0]    = !vld_reg[0] || en[1];
    assign accept   = chars.valid && en[0];

    assign chars.ready   = en[0];
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_comb
    begin
        ctrl.ld0   = accept;
        ctrl.ld1   = en[1];
        ctrl.ld2   = en[2];
        ctrl.ld3   = en[3];
        ctrl.acc   = acc_take;
        ctrl.flush = lst_reg[3];

        vld_next[0] = en[0] ? chars.valid : vld_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    dmph_power u_power (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .last   (in_item.last),
        .pow_a  (pow_a),
        .pow_b  (pow_b)
    );

    dmph_lane u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .term     (term_reg),
        .power    (pow_a),
        .sum_next (sum_a_next)
    );

    dmph_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .term     (term_reg),
        .power    (pow_b),
        .sum_next (sum_b_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            term_reg   <= TERM_W'(in_item.char_byte) + TERM_W'(1);
            lst_reg[0] <= in_item.last;
        end
        for (int i = 1; i < 4; i++)
        begin
            if (en[i])
            begin
                lst_reg[i] <= lst_reg[i-1];
            end
        end
        if (acc_take && lst_reg[3])
        begin
            out_data_reg.hash_a <= sum_a_next;
            out_data_reg.hash_b <= sum_b_next;
            out_data_reg.match  <= (sum_a_next == ref_a_reg) && (sum_b_next == ref_b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            ref_a_reg     <= HASH_W'(1);
            ref_b_reg     <= HASH_W'(1);
        end
        else
        begin
            vld_reg <= vld_next;
            if (acc_take && lst_reg[3])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_REF_A: ref_a_reg <= cfg_data;
                    REG_REF_B: ref_b_reg <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

endmodule
